[hdl/benes_bit_permutation_64_core_defines.svh]
// Assertion macros for the checker file of the bit permutation core.
`ifndef BENES_BIT_PERMUTATION_64_CORE_DEFINES_SVH
`define BENES_BIT_PERMUTATION_64_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define BBP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define BBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bbp_pkg.sv]
// Shared constants, pipeline item type and delta swap function of the permutation core.
`default_nettype none

package bbp_pkg;

	localparam int MaxStages = 16;
	localparam int WordW     = 64;
	localparam int IdxW      = 4;
	localparam int ShiftW    = 6;
	localparam int CountW    = 5;

	localparam logic KindWrite   = 1'b0;
	localparam logic KindPermute = 1'b1;

	// One transaction as it travels down the stage pipeline.
	typedef struct packed {
		logic              kind;
		logic [IdxW-1:0]   idx;
		logic [WordW-1:0]  mask;
		logic [ShiftW-1:0] shift;
		logic [WordW-1:0]  word;
	} bbp_item_t;

	// Swaps every bit pair (i + d, i) for which mask bit i is set.
	function automatic logic [WordW-1:0] delta_swap(
		input logic [WordW-1:0]  x,
		input logic [WordW-1:0]  m,
		input logic [ShiftW-1:0] d
	);
		logic [WordW-1:0] y;
		y = (x ^ (x >> d)) & m;
		return x ^ y ^ (y << d);
	endfunction

endpackage

`default_nettype wire

[hdl/benes_bit_permutation_64_core.sv]
// Top level of the programmable 64-bit Benes bit permutation pipeline.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, stage_index, stage_mask, stage_shift, data_word
// out       out_valid / out_ready  result_word
// cfg       cfg_wr_en              cfg_wr_data (stage_count)
//
// One transaction enters per cycle while the output is not stalled; a word passes the
// sixteen stage registers in turn, and each stage below stage_count applies its delta swap.
// Stage entries are written by transactions of kind 0 as they pass their stage.
// A waiting result stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and stage_count; the stage table is undefined until written.
`default_nettype none

module benes_bit_permutation_64_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bbp_pkg::CountW-1:0]  cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	input  wire logic [bbp_pkg::IdxW-1:0]    stage_index,
	input  wire logic [bbp_pkg::WordW-1:0]   stage_mask,
	input  wire logic [bbp_pkg::ShiftW-1:0]  stage_shift,
	input  wire logic [bbp_pkg::WordW-1:0]   data_word,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [bbp_pkg::WordW-1:0]        result_word
);
	import bbp_pkg::*;

	logic [CountW-1:0] stage_count_q;
	logic              en;
	logic              vld [MaxStages+1];
	bbp_item_t         item [MaxStages+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= '0;
		end else if (cfg_wr_en) begin
			stage_count_q <= cfg_wr_data;
		end
	end

	// Write transactions leave the last stage silently; only permutes are shown.
	assign out_valid   = vld[MaxStages] && (item[MaxStages].kind == KindPermute);
	assign result_word = item[MaxStages].word;
	assign en          = !out_valid || out_ready;
	assign in_ready    = en;

	assign vld[0]        = in_valid;
	assign item[0].kind  = kind;
	assign item[0].idx   = stage_index;
	assign item[0].mask  = stage_mask;
	assign item[0].shift = stage_shift;
	assign item[0].word  = data_word;

	for (genvar i = 0; i < MaxStages; i++) begin : g_stage
		bbp_stage u_stage (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.stage_id    (CountW'(i)),
			.stage_count (stage_count_q),
			.vld_in      (vld[i]),
			.item_in     (item[i]),
			.vld_out     (vld[i+1]),
			.item_out    (item[i+1])
		);
	end

endmodule

`default_nettype wire

[hdl/bbp_stage.sv]
// One network stage: its own table entry and one registered delta swap, applied below stage_count.
`default_nettype none

module bbp_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [bbp_pkg::CountW-1:0]  stage_id,
	input  wire logic [bbp_pkg::CountW-1:0]  stage_count,
	input  wire logic                        vld_in,
	input  wire bbp_pkg::bbp_item_t          item_in,
	output logic                             vld_out,
	output bbp_pkg::bbp_item_t               item_out
);
	import bbp_pkg::*;

	logic [WordW-1:0]  mask_q;
	logic [ShiftW-1:0] shift_q;
	logic              vld_s1;
	bbp_item_t         item_s1;
	bbp_item_t         item_nxt;
	logic              wr_hit;
	logic              apply;

	// A write transaction updates the entry as it passes this stage, so every
	// permute transaction behind it sees the new entry and none ahead of it does.
	assign wr_hit = en && vld_in && (item_in.kind == KindWrite)
		&& ({1'b0, item_in.idx} == stage_id);
	assign apply  = (item_in.kind == KindPermute) && (stage_id < stage_count);

	always_comb begin
		item_nxt = item_in;
		if (apply) begin
			item_nxt.word = delta_swap(item_in.word, mask_q, shift_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mask_q  <= item_in.mask;
			shift_q <= item_in.shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_nxt;
		end
	end

	assign vld_out  = vld_s1;
	assign item_out = item_s1;

endmodule

`default_nettype wire

[hdl/bbp_checker.sv]
// Port-level assertions for the permutation core and their bind statement.
`default_nettype none
`include "benes_bit_permutation_64_core_defines.svh"

module bbp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [bbp_pkg::WordW-1:0]   result_word
);

	// A result that is not taken stays on the port unchanged.
	`BBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_word), "result changed while stalled")

	// A stalled result freezes the pipeline, so no transaction may be accepted.
	`BBP_ASSERT_SAME(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input accepted during output stall")

	// The pipeline can only present a new result after it has advanced.
	`BBP_ASSERT_SAME(a_rise_needs_move, $rose(out_valid), $past(in_ready), "result appeared without pipeline advance")

	// With the output free the pipeline must always be able to advance.
	`BBP_ASSERT_SAME(a_ready_when_free, !out_valid || out_ready, in_ready, "pipeline blocked without output stall")

endmodule

bind benes_bit_permutation_64_core bbp_checker u_bbp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_word (result_word)
);

`default_nettype wire
